### rtl/core/mma_pkg.sv
// Package for the matrix multiply-accumulate block.
// Field widths, request codes, sequencer states and the MAC control struct.
// No dependencies.
package mma_pkg;

	localparam int REQ_W       = 2;
	localparam int IDX_W       = 6;
	localparam int DATA_W      = 32;
	localparam int MSIZE_W     = 4;
	localparam logic [MSIZE_W-1:0] MSIZE_RESET = 4'd8;

	typedef enum logic [1:0] {
		REQ_LOAD  = 2'd0,
		REQ_ACC   = 2'd1,
		REQ_READ  = 2'd2,
		REQ_CLEAR = 2'd3
	} mma_req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MAC,
		ST_DRAIN,
		ST_READ
	} mma_state_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} mma_ctl_t;

endpackage

### rtl/core/mma_req_if.sv
// Request and response channel interfaces of the matrix multiply-accumulate block.
// Each carries valid, ready and the item payload. Depends on mma_pkg.
interface mma_req_if import mma_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [REQ_W-1:0]         req_type;
	logic [IDX_W-1:0]         index;
	logic signed [DATA_W-1:0] a_value;
	logic signed [DATA_W-1:0] b_value;

	modport source (output valid, req_type, index, a_value, b_value, input ready);
	modport sink   (input valid, req_type, index, a_value, b_value, output ready);
endinterface

interface mma_rsp_if import mma_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DATA_W-1:0] c_value;

	modport source (output valid, c_value, input ready);
	modport sink   (input valid, c_value, output ready);
endinterface

### rtl/core/mma_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read data holds while read enable is low. No dependencies.
module mma_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                  clk,
	input  logic                  we,
	input  logic [AW-1:0]         waddr,
	input  logic [WIDTH-1:0]      wdata,
	input  logic                  re,
	input  logic [AW-1:0]         raddr,
	output logic [WIDTH-1:0]      rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

### rtl/core/mma_mac.sv
// Shared multiply-accumulate unit: registered 32x32 product, then a wrapping sum.
// Seeds each dot product with the old C word. Depends on mma_pkg.
module mma_mac import mma_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  mma_ctl_t          ctl_s1,
	input  logic [DATA_W-1:0] a_s1,
	input  logic [DATA_W-1:0] b_s1,
	input  logic [DATA_W-1:0] c_old_s1,
	output logic              busy,
	output logic              wr_en,
	output logic [DATA_W-1:0] wr_data
);
	mma_ctl_t          ctl_s2;
	logic [DATA_W-1:0] prod_s2;
	logic [DATA_W-1:0] c_old_s2;
	logic [DATA_W-1:0] sum_q;
	logic [DATA_W-1:0] acc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2  <= DATA_W'(a_s1 * b_s1);
		c_old_s2 <= c_old_s1;
		if (ctl_s2.valid) begin
			sum_q <= acc;
		end
	end

	assign acc     = (ctl_s2.first ? c_old_s2 : sum_q) + prod_s2;
	assign wr_en   = ctl_s2.valid && ctl_s2.last;
	assign wr_data = acc;
	assign busy    = ctl_s2.valid;
endmodule

### rtl/core/matrix_multiply_accumulate_top.sv
// Matrix multiply-accumulate C += A x B on one shared MAC; A, B, C in three RAMs.
// Load and clear act on acceptance; a read's item goes from C RAM read data to out_q.
// Accumulate runs n*n*n MAC steps on the single MAC, one MAC step per cycle, then drains.
// The block accepts no item while an accumulate or read is in progress.
// Reset: size 8, C reads as zero at once through per-entry valid bits, no clearing pass.
module matrix_multiply_accumulate_top import mma_pkg::*; #(
	parameter int MAX_N = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [MSIZE_W-1:0] cfg_wr_data,
	mma_req_if.sink            req,
	mma_rsp_if.source          rsp
);
	localparam int DEPTH = MAX_N * MAX_N;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(MAX_N + 1);
	localparam int CW    = 2 * NW;
	localparam int XW    = CW + IDX_W;

	mma_state_t         state_q, state_d;
	logic [MSIZE_W-1:0] msize_q;
	logic [NW-1:0]      n_use;
	logic [CW-1:0]      cells;
	logic               in_range;
	logic               accept;
	logic               start;
	logic               mac_end;
	logic               out_load;

	logic [NW-1:0]      r_q, c_q, k_q;
	logic               r_last, c_last, k_last;
	logic [AW-1:0]      a_addr_q, b_addr_q, c_addr_q, row_base_q;
	logic [AW-1:0]      idx_addr;

	mma_ctl_t           ctl_s1;
	logic [AW-1:0]      caddr_s1, caddr_s2;
	logic               cval_s1;
	logic [DEPTH-1:0]   cval_q;

	logic               ab_we;
	logic               c_re;
	logic [AW-1:0]      c_raddr;
	logic [DATA_W-1:0]  a_rd, b_rd, c_rd;
	logic               mac_busy;
	logic               c_we;
	logic [DATA_W-1:0]  c_wdata;

	logic               rd_ok_q;
	logic               out_v_q;
	logic [DATA_W-1:0]  out_q;

	always_comb begin
		if (msize_q == '0) begin
			n_use = NW'(1);
		end else if ({1'b0, msize_q} > (MSIZE_W + 1)'(MAX_N)) begin
			n_use = NW'(MAX_N);
		end else begin
			n_use = NW'(msize_q);
		end
	end

	assign cells    = CW'(n_use) * CW'(n_use);
	assign in_range = XW'(req.index) < XW'(cells);
	assign idx_addr = AW'(req.index);
	assign accept   = req.valid && req.ready;
	assign start    = accept && (req.req_type == REQ_ACC);
	assign k_last   = k_q == n_use - NW'(1);
	assign c_last   = c_q == n_use - NW'(1);
	assign r_last   = r_q == n_use - NW'(1);
	assign mac_end  = k_last && c_last && r_last;
	assign out_load = !out_v_q || rsp.ready;
	assign ab_we    = accept && (req.req_type == REQ_LOAD) && in_range;
	assign c_re     = (state_q == ST_MAC) || (accept && (req.req_type == REQ_READ));
	assign c_raddr  = (state_q == ST_MAC) ? c_addr_q : idx_addr;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req.ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				if (accept) begin
					case (req.req_type)
						REQ_ACC:  state_d = ST_MAC;
						REQ_READ: state_d = ST_READ;
						default:  state_d = ST_IDLE;
					endcase
				end
			end
			ST_MAC: begin
				if (mac_end) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!ctl_s1.valid && !mac_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_READ: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			msize_q <= MSIZE_RESET;
			ctl_s1  <= '0;
			cval_q  <= '0;
			out_v_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				msize_q <= cfg_wr_data;
			end
			ctl_s1.valid <= state_q == ST_MAC;
			ctl_s1.first <= k_q == '0;
			ctl_s1.last  <= k_last;
			if (accept && (req.req_type == REQ_CLEAR)) begin
				cval_q <= '0;
			end else if (c_we) begin
				cval_q[caddr_s2] <= 1'b1;
			end
			if (state_q == ST_READ && out_load) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			r_q        <= '0;
			c_q        <= '0;
			k_q        <= '0;
			a_addr_q   <= '0;
			b_addr_q   <= '0;
			c_addr_q   <= '0;
			row_base_q <= '0;
		end else if (state_q == ST_MAC) begin
			if (!k_last) begin
				k_q      <= k_q + NW'(1);
				a_addr_q <= a_addr_q + AW'(1);
				b_addr_q <= b_addr_q + AW'(n_use);
			end else begin
				k_q      <= '0;
				c_addr_q <= c_addr_q + AW'(1);
				if (!c_last) begin
					c_q      <= c_q + NW'(1);
					a_addr_q <= row_base_q;
					b_addr_q <= AW'(c_q) + AW'(1);
				end else begin
					c_q        <= '0;
					r_q        <= r_q + NW'(1);
					a_addr_q   <= a_addr_q + AW'(1);
					row_base_q <= a_addr_q + AW'(1);
					b_addr_q   <= '0;
				end
			end
		end
		caddr_s1 <= c_addr_q;
		caddr_s2 <= caddr_s1;
		if (c_re) begin
			cval_s1 <= cval_q[c_raddr];
		end
		if (accept && (req.req_type == REQ_READ)) begin
			rd_ok_q <= in_range && cval_q[idx_addr];
		end
		if (state_q == ST_READ && out_load) begin
			out_q <= rd_ok_q ? c_rd : '0;
		end
	end

	mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (ab_we),
		.waddr (idx_addr),
		.wdata (DATA_W'(req.a_value)),
		.re    (state_q == ST_MAC),
		.raddr (a_addr_q),
		.rdata (a_rd)
	);

	mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (ab_we),
		.waddr (idx_addr),
		.wdata (DATA_W'(req.b_value)),
		.re    (state_q == ST_MAC),
		.raddr (b_addr_q),
		.rdata (b_rd)
	);

	mma_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_ram_c (
		.clk   (clk),
		.we    (c_we),
		.waddr (caddr_s2),
		.wdata (c_wdata),
		.re    (c_re),
		.raddr (c_raddr),
		.rdata (c_rd)
	);

	mma_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_s1   (ctl_s1),
		.a_s1     (a_rd),
		.b_s1     (b_rd),
		.c_old_s1 (cval_s1 ? c_rd : '0),
		.busy     (mac_busy),
		.wr_en    (c_we),
		.wr_data  (c_wdata)
	);

	assign rsp.valid   = out_v_q;
	assign rsp.c_value = out_q;

`ifndef SYNTHESIS
	a_cwrite_in_acc: assert property (@(posedge clk) disable iff (!arst_n)
		c_we |-> (state_q == ST_MAC || state_q == ST_DRAIN))
		else $error("C written outside an accumulate");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> (!ctl_s1.valid && !mac_busy))
		else $error("MAC pipeline busy while idle");

	a_read_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.req_type == REQ_READ) |=> state_q == ST_READ)
		else $error("read item did not enter read state");

	a_addr_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_MAC |-> (XW'(a_addr_q) < XW'(cells) && XW'(b_addr_q) < XW'(cells)))
		else $error("operand address beyond matrix");
`endif
endmodule

### tb/testbench.sv
// Self-checking bench for matrix_multiply_accumulate_top: random load, accumulate, read and
// clear items across many matrix sizes, checked by a C shadow kept in a scoreboard class.
// Depends on mma_pkg, mma_req_if, mma_rsp_if and the block itself.
import mma_pkg::*;

typedef struct packed {
	mma_req_t          kind;
	logic [IDX_W-1:0]  index;
	logic [DATA_W-1:0] a_value;
	logic [DATA_W-1:0] b_value;
} mma_item_t;

class mma_shadow;
	logic [DATA_W-1:0]  a_mem [64];
	logic [DATA_W-1:0]  b_mem [64];
	logic [DATA_W-1:0]  c_mem [64];
	bit                 loaded [64];
	logic [MSIZE_W-1:0] size_reg;
	logic [DATA_W-1:0]  pending_c [$];
	int                 errors;
	int                 checked;

	function new();
		size_reg = MSIZE_RESET;
		foreach (c_mem[i]) begin
			c_mem[i] = '0;
			loaded[i] = 1'b0;
		end
		errors = 0;
		checked = 0;
	endfunction

	function int order();
		int n;
		n = int'(size_reg);
		if (n < 1)
			n = 1;
		if (n > 8)
			n = 8;
		return n;
	endfunction

	function void write_size(logic [MSIZE_W-1:0] v);
		size_reg = v;
	endfunction

	function bit ready_to_multiply();
		int cells;
		cells = order() * order();
		for (int i = 0; i < cells; i++)
			if (!loaded[i])
				return 1'b0;
		return 1'b1;
	endfunction

	// Returns 0 when the block ignores the item.
	function bit note_request(mma_item_t it);
		int               n;
		int               cells;
		logic [DATA_W-1:0] sum;
		n = order();
		cells = n * n;
		case (it.kind)
		REQ_LOAD: begin
			if (it.index >= cells)
				return 1'b0;
			a_mem[it.index] = it.a_value;
			b_mem[it.index] = it.b_value;
			loaded[it.index] = 1'b1;
		end
		REQ_ACC: begin
			for (int r = 0; r < n; r++)
				for (int c = 0; c < n; c++) begin
					sum = '0;
					for (int k = 0; k < n; k++)
						sum += a_mem[r*n+k] * b_mem[k*n+c];
					c_mem[r*n+c] += sum;
				end
		end
		REQ_READ: begin
			pending_c.push_back((it.index < cells) ? c_mem[it.index] : '0);
		end
		default: begin
			foreach (c_mem[i])
				c_mem[i] = '0;
		end
		endcase
		return 1'b1;
	endfunction

	function void check_c_value(logic [DATA_W-1:0] got);
		logic [DATA_W-1:0] want;
		if (pending_c.size() == 0) begin
			$error("c_value: no item expected, actual %0d", $signed(got));
			errors++;
			return;
		end
		want = pending_c.pop_front();
		checked++;
		if (got !== want) begin
			$error("c_value mismatch: expected %0d actual %0d", $signed(want), $signed(got));
			errors++;
		end
	endfunction
endclass

module testbench;
	logic               clk;
	logic               arst_n;
	logic               cfg_wr_en;
	logic [MSIZE_W-1:0] cfg_wr_data;

	mma_req_if req();
	mma_rsp_if rsp();

	matrix_multiply_accumulate_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.req(req),
		.rsp(rsp)
	);

	mma_shadow shadow;
	int        applied_count;
	int        acc_count;
	int        size_writes;
	bit        no_gaps;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30000000;
		$display("[matrix_multiply_accumulate_top] ERROR");
		$finish;
	end

	function automatic int gap_len();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [DATA_W-1:0] pick_word();
		case ($urandom_range(7))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'hffff_ffff;
		3: return 32'h0000_0000;
		default: return $urandom;
		endcase
	endfunction

	function automatic int pick_index(int cells);
		if ($urandom_range(9) == 0)
			return $urandom_range(63);
		return $urandom_range(cells - 1);
	endfunction

	function automatic mma_item_t make_item(mma_req_t kind, int idx,
			logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		mma_item_t it;
		it.kind = kind;
		it.index = IDX_W'(idx);
		it.a_value = a;
		it.b_value = b;
		return it;
	endfunction

	function automatic mma_item_t random_request();
		int        n;
		int        cells;
		int        acc_w;
		int        r;
		mma_item_t it;
		n = shadow.order();
		cells = n * n;
		acc_w = (n <= 4) ? 15 : 6;
		r = $urandom_range(99);
		it = make_item(REQ_READ, $urandom_range(63), $urandom, $urandom);
		if (r < 40)
			it = make_item(REQ_LOAD, pick_index(cells), pick_word(), pick_word());
		else if (r < 40 + acc_w && shadow.ready_to_multiply())
			it.kind = REQ_ACC;
		else if (r < 93)
			it.index = IDX_W'(pick_index(cells));
		else
			it.kind = REQ_CLEAR;
		return it;
	endfunction

	task automatic send_item(input mma_item_t it);
		int g;
		req.valid <= 1'b1;
		req.req_type <= it.kind;
		req.index <= it.index;
		req.a_value <= it.a_value;
		req.b_value <= it.b_value;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		if (shadow.note_request(it))
			applied_count++;
		if (it.kind == REQ_ACC)
			acc_count++;
		g = gap_len();
		if (g > 0) begin
			req.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		req.valid <= 1'b0;
		@(posedge clk);
		for (int k = 0; k < 200000 && shadow.pending_c.size() != 0; k++)
			@(posedge clk);
		repeat (600) @(posedge clk);
	endtask

	task automatic write_size(input logic [MSIZE_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow.write_size(v);
		size_writes++;
	endtask

	task automatic refill();
		int cells;
		cells = shadow.order() * shadow.order();
		for (int i = 0; i < cells; i++)
			send_item(make_item(REQ_LOAD, i, pick_word(), pick_word()));
	endtask

	initial begin
		int hold;
		int stall;
		rsp.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			hold = ($urandom_range(99) < 80) ? $urandom_range(8, 1) : $urandom_range(200, 50);
			stall = $urandom_range(99);
			stall = (stall < 60) ? 0 : (stall < 90) ? $urandom_range(3, 1) :
				$urandom_range(60, 10);
			@(posedge clk);
			rsp.ready <= 1'b1;
			repeat (hold - 1) @(posedge clk);
			if (stall > 0) begin
				@(posedge clk);
				rsp.ready <= 1'b0;
				repeat (stall - 1) @(posedge clk);
			end
		end
	end

	always @(posedge clk)
		if (arst_n && rsp.valid && rsp.ready)
			shadow.check_c_value(rsp.c_value);

	initial begin
		logic [MSIZE_W-1:0] sizes [11];
		int                 target;
		shadow = new();
		applied_count = 0;
		acc_count = 0;
		size_writes = 0;
		no_gaps = 1'b0;
		sizes = '{4'd1, 4'd0, 4'd5, 4'd15, 4'd3, 4'd8, 4'd6, 4'd2, 4'd4, 4'd7, 4'd8};
		arst_n <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_wr_data <= '0;
		req.valid <= 1'b0;
		req.req_type <= REQ_LOAD;
		req.index <= '0;
		req.a_value <= '0;
		req.b_value <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// C reads zero out of reset
		send_item(make_item(REQ_READ, 0, '0, '0));
		wait_idle();
		write_size(4'd2);
		send_item(make_item(REQ_LOAD, 0, 32'h8000_0000, 32'h7fff_ffff));
		send_item(make_item(REQ_LOAD, 1, 32'h7fff_ffff, 32'hffff_ffff));
		send_item(make_item(REQ_LOAD, 2, 32'hffff_ffff, 32'h8000_0000));
		send_item(make_item(REQ_LOAD, 3, 32'h0000_0000, 32'h1234_5678));
		send_item(make_item(REQ_LOAD, 63, 32'hffff_ffff, 32'hffff_ffff));
		send_item(make_item(REQ_LOAD, 4, 32'h5555_5555, 32'haaaa_aaaa));
		send_item(make_item(REQ_ACC, 0, '0, '0));
		for (int i = 0; i < 4; i++)
			send_item(make_item(REQ_READ, i, '0, '0));
		send_item(make_item(REQ_READ, 63, '0, '0));
		send_item(make_item(REQ_READ, 4, '0, '0));
		send_item(make_item(REQ_ACC, 0, '0, '0));
		send_item(make_item(REQ_READ, 3, '0, '0));
		send_item(make_item(REQ_CLEAR, 0, '0, '0));
		send_item(make_item(REQ_READ, 1, '0, '0));

		foreach (sizes[p]) begin
			wait_idle();
			write_size(sizes[p]);
			no_gaps = ($urandom_range(3) == 0);
			target = applied_count + 105;
			if (!shadow.ready_to_multiply() || $urandom_range(1) == 0)
				refill();
			while (applied_count < target)
				send_item(random_request());
		end

		wait_idle();
		if (shadow.pending_c.size() != 0) begin
			$error("c_value: %0d expected items never arrived", shadow.pending_c.size());
			shadow.errors++;
		end
		$display("Applied %0d requests incl. %0d accumulates; %0d reads checked over %0d sizes",
			applied_count, acc_count, shadow.checked, size_writes);
		if (shadow.errors == 0)
			$display("[matrix_multiply_accumulate_top] OK");
		else
			$display("[matrix_multiply_accumulate_top] ERROR");
		$finish;
	end
endmodule

### files.f
rtl/core/mma_pkg.sv
rtl/core/mma_req_if.sv
rtl/core/mma_ram.sv
rtl/core/mma_mac.sv
rtl/core/matrix_multiply_accumulate_top.sv
tb/testbench.sv
